>>> src/htb_pkg.sv
// ----------------------------------------------------------------------------
// htb_pkg: shared types and helpers for the hex text to bytes converter
// Result kinds, the per-character result bundle and character classifiers.
// ----------------------------------------------------------------------------
package htb_pkg;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF    = 8'h66;
   localparam logic [7:0] CHAR_X     = 8'h78;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // everything one character produces: up to two data bytes, then an optional
   // closing end/error word
   typedef struct packed {
      logic [7:0] data0;
      logic [7:0] data1;
      logic [1:0] n_data;
      logic       has_final;
      logic [1:0] final_kind;
   } bundle_type;

   typedef struct packed {
      logic       valid;
      bundle_type bundle;
   } slot_type;

   function automatic logic is_separator(input logic [7:0] c);
      logic ws;
      logic punct;
      ws    = (c >= 8'h09 && c <= 8'h0D) || (c == 8'h20);
      punct = (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
              (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
      return ws || punct;
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= CHAR_ZERO && c <= CHAR_NINE) || (c >= CHAR_UA && c <= CHAR_UF) ||
             (c >= CHAR_LA && c <= CHAR_LF);
   endfunction

   // nibble of a hex digit; don't care for anything else
   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] t;
      t = 8'h00;
      if (c <= CHAR_NINE) begin
         t = c - CHAR_ZERO;
      end else if (c <= CHAR_UF) begin
         t = c - CHAR_UA + 8'd10;
      end else begin
         t = c - CHAR_LA + 8'd10;
      end
      return t[3:0];
   endfunction

endpackage

>>> src/htb_front.sv
// ----------------------------------------------------------------------------
// htb_front: character classifier and pairing state
// Takes one character a cycle on accept; builds the bundle of words it gives.
// ----------------------------------------------------------------------------
module htb_front import htb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] char_code,
   input  logic       last_char,
   output logic       bundle_push,
   output bundle_type bundle
);

   logic [3:0] pend_ff, pend_in;
   logic       has_pend_ff, has_pend_in;
   logic       held_ff, held_in;
   logic       failed_ff, failed_in;
   logic       any_ff, any_in;

   always_comb begin
      logic dropped;
      logic err;
      logic [3:0] v;
      pend_in     = pend_ff;
      has_pend_in = has_pend_ff;
      held_in     = held_ff;
      failed_in   = failed_ff;
      any_in      = any_ff;
      bundle      = '0;
      dropped     = 1'b0;
      err         = 1'b0;
      v           = hex_nibble(char_code);

      if (failed_ff) begin
         if (last_char) begin
            pend_in = 4'h0; has_pend_in = 1'b0; held_in = 1'b0;
            failed_in = 1'b0; any_in = 1'b0;
         end
      end else begin
         if (held_ff) begin
            held_in = 1'b0;
            if (char_code == CHAR_X) begin
               if (has_pend_in) begin
                  bundle.data0  = {4'h0, pend_in};
                  bundle.n_data = 2'd1;
                  any_in        = 1'b1;
               end
               has_pend_in = 1'b0;
               pend_in     = 4'h0;
               dropped     = 1'b1;
            end else if (has_pend_in) begin
               // held '0' closes the pending pair
               bundle.data0  = {pend_in, 4'h0};
               bundle.n_data = 2'd1;
               any_in        = 1'b1;
               has_pend_in   = 1'b0;
               pend_in       = 4'h0;
            end else begin
               pend_in     = 4'h0;
               has_pend_in = 1'b1;
            end
         end

         if (!dropped) begin
            if (char_code == CHAR_ZERO && !last_char) begin
               held_in = 1'b1;
            end else if (is_separator(char_code)) begin
               if (has_pend_in) begin
                  if (bundle.n_data == 2'd0) bundle.data0 = {4'h0, pend_in};
                  else                       bundle.data1 = {4'h0, pend_in};
                  bundle.n_data = bundle.n_data + 2'd1;
                  any_in        = 1'b1;
               end
               has_pend_in = 1'b0;
               pend_in     = 4'h0;
            end else if (is_hex(char_code)) begin
               if (has_pend_in) begin
                  if (bundle.n_data == 2'd0) bundle.data0 = {pend_in, v};
                  else                       bundle.data1 = {pend_in, v};
                  bundle.n_data = bundle.n_data + 2'd1;
                  any_in        = 1'b1;
                  has_pend_in   = 1'b0;
                  pend_in       = 4'h0;
               end else begin
                  pend_in     = v;
                  has_pend_in = 1'b1;
               end
            end else begin
               err                = 1'b1;
               bundle.has_final   = 1'b1;
               bundle.final_kind  = KIND_ERROR;
               pend_in = 4'h0; has_pend_in = 1'b0; held_in = 1'b0; any_in = 1'b0;
               failed_in = !last_char;
            end
         end

         if (last_char && !err) begin
            if (has_pend_in) begin
               if (bundle.n_data == 2'd0) bundle.data0 = {4'h0, pend_in};
               else                       bundle.data1 = {4'h0, pend_in};
               bundle.n_data = bundle.n_data + 2'd1;
               any_in        = 1'b1;
            end
            bundle.has_final  = 1'b1;
            bundle.final_kind = any_in ? KIND_END : KIND_ERROR;
            pend_in = 4'h0; has_pend_in = 1'b0; held_in = 1'b0;
            failed_in = 1'b0; any_in = 1'b0;
         end
      end
   end

   assign bundle_push = accept && (bundle.n_data != 2'd0 || bundle.has_final);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= 4'h0;
         has_pend_ff <= 1'b0;
         held_ff     <= 1'b0;
         failed_ff   <= 1'b0;
         any_ff      <= 1'b0;
      end else if (accept) begin
         pend_ff     <= pend_in;
         has_pend_ff <= has_pend_in;
         held_ff     <= held_in;
         failed_ff   <= failed_in;
         any_ff      <= any_in;
      end
   end

endmodule

>>> src/htb_queue.sv
// ----------------------------------------------------------------------------
// htb_queue: short bundle queue between classifier and result sequencer
// Register-based FIFO; head entry presented combinationally.
// ----------------------------------------------------------------------------
module htb_queue import htb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_bundle,
   output logic       full,
   input  logic       pop,
   output slot_type   head
);

   bundle_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]       count_ff, count_in;
   logic                    do_push, do_pop;

   assign full    = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && (count_ff != '0);

   assign head = {(count_ff != '0), entry_ff[rd_ptr_ff]};

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> src/htb_back.sv
// ----------------------------------------------------------------------------
// htb_back: result sequencer
// Walks the head bundle one word at a time: data bytes, then any closing word.
// ----------------------------------------------------------------------------
module htb_back import htb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  slot_type   head,
   output logic       head_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_byte_value,
   output logic [1:0] rsp_kind,
   output logic       rsp_last
);

   logic [1:0] idx_ff, idx_in;
   logic       is_data;
   logic       final_word;
   logic       take;

   assign rsp_empty = !head.valid;
   assign take      = rsp_pop && head.valid;
   assign is_data   = (idx_ff < head.bundle.n_data);

   // last word of this bundle
   assign final_word = is_data ? (idx_ff + 2'd1 == head.bundle.n_data) && !head.bundle.has_final
                               : 1'b1;

   assign head_pop = take && final_word;

   always_comb begin
      if (is_data) begin
         rsp_byte_value = (idx_ff == 2'd0) ? head.bundle.data0 : head.bundle.data1;
         rsp_kind       = KIND_DATA;
         rsp_last       = 1'b0;
      end else begin
         rsp_byte_value = 8'h00;
         rsp_kind       = head.bundle.final_kind;
         rsp_last       = 1'b1;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = final_word ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

>>> src/hex_text_to_bytes.sv
// ----------------------------------------------------------------------------
// hex_text_to_bytes: ASCII hex text to byte stream converter
// Pairs hex digits into bytes, closes each text run with an end/error word.
// ----------------------------------------------------------------------------
//  channel   direction  handshake       payload
//  req_      in         push / full     char_code[7:0], last_char
//  rsp_      out        pop / empty     byte_value[7:0], kind[1:0], last
//
//  One character accepted per cycle while the 4-entry bundle queue has room.
//  A character yields 0..3 words; the result side drains one word per cycle
//  while rsp_pop is high, so sustained input rate is one per cycle when each
//  character gives at most one word. First word is registered in the queue.
//  Synchronous reset clears pairing state, queue pointers and word index.
//  Either side may stall independently; the queue absorbs the difference.
module hex_text_to_bytes import htb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_char_code,
   input  logic       req_last_char,
   input  logic       req_push,
   output logic       req_full,
   output logic [7:0] rsp_byte_value,
   output logic [1:0] rsp_kind,
   output logic       rsp_last,
   output logic       rsp_empty,
   input  logic       rsp_pop
);

   logic       accept;
   logic       bundle_push;
   bundle_type bundle;
   slot_type   head;
   logic       head_pop;

   assign accept = req_push && !req_full;

   htb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_code   (req_char_code),
      .last_char   (req_last_char),
      .bundle_push (bundle_push),
      .bundle      (bundle)
   );

   htb_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (bundle_push),
      .push_bundle (bundle),
      .full        (req_full),
      .pop         (head_pop),
      .head        (head)
   );

   htb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .head_pop       (head_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_byte_value (rsp_byte_value),
      .rsp_kind       (rsp_kind),
      .rsp_last       (rsp_last)
   );

endmodule

>>> test/hex_text_to_bytes_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hex_text_to_bytes_tb: self-checking bench for the hex text to bytes converter
// Drives character words on the push/full side and pops result words on the
// empty/pop side. Expected words come from a behavioral converter kept in the
// bench (typed in for a few directed rows). Both sides idle at random in
// several phases, and one long pop hold-off fills the block up.
// ----------------------------------------------------------------------------
module hex_text_to_bytes_tb;
   import htb_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int PREDICTED     = -1;
   localparam int ITEMS_PER_PHASE = 110;

   typedef struct packed {
      logic [7:0] value;
      logic [1:0] kind;
      logic       fin;
   } rsp_word_type;

   // one character of the directed table; typed rows carry their own words
   typedef struct packed {
      logic [7:0]   ch;
      logic         fin;
      logic         typed;
      logic [1:0]   n_typed;
      rsp_word_type w0;
      rsp_word_type w1;
      rsp_word_type w2;
   } text_row_type;

   localparam rsp_word_type NO_WORD  = '0;
   localparam rsp_word_type ERR_WORD = {8'h00, KIND_ERROR, 1'b1};

   logic       clock;
   logic       reset         = 1'b1;
   logic [7:0] req_char_code = 8'h00;
   logic       req_last_char = 1'b0;
   logic       req_push      = 1'b0;
   logic       req_full;
   logic [7:0] rsp_byte_value;
   logic [1:0] rsp_kind;
   logic       rsp_last;
   logic       rsp_empty;
   logic       rsp_pop       = 1'b0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_off_left  = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   rsp_word_type expected_words[$];
   rsp_word_type step_words[$];
   text_row_type directed_text[$];

   // converter state
   logic [3:0] pend_nibble = 4'h0;
   logic       pend_valid  = 1'b0;
   logic       zero_held   = 1'b0;
   logic       run_failed  = 1'b0;
   logic       byte_seen   = 1'b0;

   hex_text_to_bytes DUT (
      .clock          (clock),
      .reset          (reset),
      .req_char_code  (req_char_code),
      .req_last_char  (req_last_char),
      .req_push       (req_push),
      .req_full       (req_full),
      .rsp_byte_value (rsp_byte_value),
      .rsp_kind       (rsp_kind),
      .rsp_last       (rsp_last),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- converter

   function automatic void emit_word(input logic [7:0] value, input logic [1:0] kind,
                                     input logic fin);
      rsp_word_type w;
      w = {value, kind, fin};
      step_words.push_back(w);
      if (kind == KIND_DATA) begin
         byte_seen = 1'b1;
      end
   endfunction

   function automatic void close_pair();
      if (pend_valid) begin
         emit_word({4'h0, pend_nibble}, KIND_DATA, 1'b0);
      end
      pend_valid  = 1'b0;
      pend_nibble = 4'h0;
   endfunction

   function automatic void add_nibble(input logic [3:0] nib);
      if (pend_valid) begin
         emit_word({pend_nibble, nib}, KIND_DATA, 1'b0);
         pend_valid  = 1'b0;
         pend_nibble = 4'h0;
      end else begin
         pend_nibble = nib;
         pend_valid  = 1'b1;
      end
   endfunction

   function automatic void clear_run();
      pend_nibble = 4'h0;
      pend_valid  = 1'b0;
      zero_held   = 1'b0;
      run_failed  = 1'b0;
      byte_seen   = 1'b0;
   endfunction

   function automatic logic is_break(input logic [7:0] ch);
      return (ch >= 8'h09 && ch <= 8'h0D) || ch == 8'h20 ||
             (ch >= 8'h21 && ch <= 8'h2F) || (ch >= 8'h3A && ch <= 8'h40) ||
             (ch >= 8'h5B && ch <= 8'h60) || (ch >= 8'h7B && ch <= 8'h7E);
   endfunction

   // 0..15 for a hex digit, 16 for anything else
   function automatic logic [4:0] digit_of(input logic [7:0] ch);
      logic [7:0] t;
      t = 8'd16;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         t = ch - CHAR_ZERO;
      end else if (ch >= CHAR_UA && ch <= CHAR_UF) begin
         t = ch - CHAR_UA + 8'd10;
      end else if (ch >= CHAR_LA && ch <= CHAR_LF) begin
         t = ch - CHAR_LA + 8'd10;
      end
      return t[4:0];
   endfunction

   // words caused by one character land in step_words
   function automatic void convert_char(input logic [7:0] ch, input logic fin);
      logic [4:0] d;
      logic       dropped;
      step_words.delete();
      d       = digit_of(ch);
      dropped = 1'b0;
      if (run_failed) begin
         if (fin) begin
            clear_run();
         end
         return;
      end
      if (zero_held) begin
         zero_held = 1'b0;
         if (ch == CHAR_X) begin
            close_pair();
            dropped = 1'b1;
         end else begin
            add_nibble(4'h0);
         end
      end
      if (!dropped) begin
         if (ch == CHAR_ZERO && !fin) begin
            zero_held = 1'b1;
         end else if (is_break(ch)) begin
            close_pair();
         end else if (d < 5'd16) begin
            add_nibble(d[3:0]);
         end else begin
            emit_word(8'h00, KIND_ERROR, 1'b1);
            clear_run();
            run_failed = !fin;
            return;
         end
      end
      if (fin) begin
         close_pair();
         emit_word(8'h00, byte_seen ? KIND_END : KIND_ERROR, 1'b1);
         clear_run();
      end
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic text_row_type text_row(input logic [7:0] ch, input logic fin,
                                             input int n, input rsp_word_type w0,
                                             input rsp_word_type w1,
                                             input rsp_word_type w2);
      text_row_type r;
      r.ch      = ch;
      r.fin     = fin;
      r.typed   = (n >= 0);
      r.n_typed = (n >= 0) ? n[1:0] : 2'd0;
      r.w0      = w0;
      r.w1      = w1;
      r.w2      = w2;
      return r;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) begin
         return CHAR_ZERO + n;
      end
      return (($urandom_range(1) == 0) ? CHAR_UA : CHAR_LA) + n - 8'd10;
   endfunction

   function automatic logic [7:0] pick_break();
      case ($urandom_range(5))
         0: return 8'h09 + 8'($urandom_range(4));
         1: return 8'h20;
         2: return 8'h21 + 8'($urandom_range(14));
         3: return 8'h3A + 8'($urandom_range(6));
         4: return 8'h5B + 8'($urandom_range(5));
         default: return 8'h7B + 8'($urandom_range(3));
      endcase
   endfunction

   // mostly well-formed hex text, with "0x" prefixes and a few bad characters
   function automatic logic [7:0] pick_char(input logic [7:0] prev);
      int roll;
      roll = $urandom_range(99);
      if (prev == CHAR_ZERO && roll < 50) begin
         return CHAR_X;
      end
      if (roll < 40) return hex_char(4'($urandom_range(15)));
      if (roll < 52) return CHAR_ZERO;
      if (roll < 80) return pick_break();
      if (roll < 82) return CHAR_X;
      if (roll < 85) return 8'($urandom_range(255));
      return hex_char(4'($urandom_range(15)));
   endfunction

   task automatic send_char(input text_row_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_char_code <= r.ch;
      req_last_char <= r.fin;
      req_push      <= 1'b1;
      @(posedge clock);
      while (req_full) begin
         @(posedge clock);
      end
      convert_char(r.ch, r.fin);
      if (!r.typed) begin
         foreach (step_words[k]) begin
            expected_words.push_back(step_words[k]);
         end
      end else begin
         if (r.n_typed > 0) expected_words.push_back(r.w0);
         if (r.n_typed > 1) expected_words.push_back(r.w1);
         if (r.n_typed > 2) expected_words.push_back(r.w2);
      end
   endtask

   // ---------------------------------------------------------------- result side

   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic note_mismatch(input string what, input rsp_word_type want,
                                input rsp_word_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s: expected value %02h kind %0d last %0b, %s %02h kind %0d last %0b",
                  $realtime, what, want.value, want.kind, want.fin, "got value",
                  got.value, got.kind, got.fin);
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         got = {rsp_byte_value, rsp_kind, rsp_last};
         if (expected_words.size() == 0) begin
            note_mismatch("unexpected word", NO_WORD, got);
         end else begin
            want = expected_words.pop_front();
            if (got.value !== want.value || got.kind !== want.kind || got.fin !== want.fin) begin
               note_mismatch("word mismatch", want, got);
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("hex_text_to_bytes_tb: FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- main

   initial begin
      int send_idle_by_phase[4];
      int recv_stall_by_phase[4];
      int run_left;
      logic [7:0] prev_ch;
      logic [7:0] ch;
      send_idle_by_phase  = '{0, 61, 0, 34};
      recv_stall_by_phase = '{0, 0, 61, 34};

      // pairs, separators, 0x prefix, final zero, errors and silent tails
      directed_text.push_back(text_row("F",   1'b0, 0, NO_WORD, NO_WORD, NO_WORD));
      directed_text.push_back(text_row("F",   1'b0, 1, {8'hFF, KIND_DATA, 1'b0},
                                       NO_WORD, NO_WORD));
      directed_text.push_back(text_row(8'h09, 1'b0, PREDICTED, NO_WORD, NO_WORD, NO_WORD));
      directed_text.push_back(text_row("a",   1'b0, PREDICTED, NO_WORD, NO_WORD, NO_WORD));
      directed_text.push_back(text_row("9",   1'b0, PREDICTED, NO_WORD, NO_WORD, NO_WORD));
      directed_text.push_back(text_row("0",   1'b0, PREDICTED, NO_WORD, NO_WORD, NO_WORD));
      directed_text.push_back(text_row("x",   1'b0, PREDICTED, NO_WORD, NO_WORD, NO_WORD));
      directed_text.push_back(text_row("A",   1'b0, PREDICTED, NO_WORD, NO_WORD, NO_WORD));
      directed_text.push_back(text_row(8'h7E, 1'b0, PREDICTED, NO_WORD, NO_WORD, NO_WORD));
      directed_text.push_back(text_row("0",   1'b1, 2, {8'h00, KIND_DATA, 1'b0},
                                       {8'h00, KIND_END, 1'b1}, NO_WORD));
      directed_text.push_back(text_row("f",   1'b0, PREDICTED, NO_WORD, NO_WORD, NO_WORD));
      directed_text.push_back(text_row("0",   1'b0, PREDICTED, NO_WORD, NO_WORD, NO_WORD));
      directed_text.push_back(text_row("7",   1'b1, PREDICTED, NO_WORD, NO_WORD, NO_WORD));
      directed_text.push_back(text_row("A",   1'b0, PREDICTED, NO_WORD, NO_WORD, NO_WORD));
      directed_text.push_back(text_row("0",   1'b0, PREDICTED, NO_WORD, NO_WORD, NO_WORD));
      directed_text.push_back(text_row(8'hFF, 1'b0, PREDICTED, NO_WORD, NO_WORD, NO_WORD));
      directed_text.push_back(text_row("B",   1'b0, 0, NO_WORD, NO_WORD, NO_WORD));
      directed_text.push_back(text_row(8'h00, 1'b1, 0, NO_WORD, NO_WORD, NO_WORD));
      directed_text.push_back(text_row(8'h20, 1'b1, 1, ERR_WORD, NO_WORD, NO_WORD));
      directed_text.push_back(text_row("x",   1'b1, 1, ERR_WORD, NO_WORD, NO_WORD));
      directed_text.push_back(text_row(8'h80, 1'b0, 1, ERR_WORD, NO_WORD, NO_WORD));
      directed_text.push_back(text_row(8'h0D, 1'b1, 0, NO_WORD, NO_WORD, NO_WORD));
      directed_text.push_back(text_row("g",   1'b1, 1, ERR_WORD, NO_WORD, NO_WORD));
      directed_text.push_back(text_row(8'h00, 1'b1, 1, ERR_WORD, NO_WORD, NO_WORD));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_text[i]) begin
         send_char(directed_text[i]);
      end

      prev_ch  = 8'h00;
      run_left = $urandom_range(1, 16);
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = send_idle_by_phase[phase];
         recv_stall_pct = recv_stall_by_phase[phase];
         // long pop hold-off while words keep coming, so full must assert
         if (phase == 0) begin
            hold_off_left = 80;
         end
         repeat (ITEMS_PER_PHASE) begin
            ch = pick_char(prev_ch);
            send_char(text_row(ch, run_left == 1, PREDICTED, NO_WORD, NO_WORD, NO_WORD));
            prev_ch = ch;
            if (run_left == 1) begin
               run_left = $urandom_range(1, 16);
            end else begin
               run_left--;
            end
         end
      end
      @(negedge clock);
      req_push <= 1'b0;

      while (expected_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("hex_text_to_bytes_tb: PASS");
      end else begin
         $display("hex_text_to_bytes_tb: FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
src/htb_pkg.sv
src/htb_front.sv
src/htb_queue.sv
src/htb_back.sv
src/hex_text_to_bytes.sv
test/hex_text_to_bytes_tb.sv
